// ===== rtl/lscc_pkg.sv =====
// shared types and constants for the line sensor calibrated classifier
// no dependencies; used by every rtl file of the block
`timescale 1ns / 1ps
`default_nettype none

package lscc_pkg;

  // converter full scale and field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam logic [SAMPLE_W-1:0] ADC_MAX = 12'd4095;

  // request mode codes
  localparam logic [1:0] MODE_MEASURE   = 2'd0;
  localparam logic [1:0] MODE_CAP_WHITE = 2'd1;
  localparam logic [1:0] MODE_CAP_BLACK = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CAL_HALF  = 2'd0;
  localparam logic [1:0] REG_WHITE_DEF = 2'd1;
  localparam logic [1:0] REG_BLACK_DEF = 2'd2;

  // reset values
  localparam logic [SAMPLE_W-1:0] CAL_HALF_RST  = 12'd200;
  localparam logic [SAMPLE_W-1:0] WHITE_DEF_RST = 12'd1000;
  localparam logic [SAMPLE_W-1:0] BLACK_DEF_RST = 12'd3000;

  // input request
  typedef struct packed {
    logic [1:0]          mode;
    logic                side;
    logic [SAMPLE_W-1:0] sample;
  } in_req_t;

  // result
  typedef struct packed {
    logic       color;
    logic [6:0] percent;
    logic [8:0] white_level;
  } out_res_t;

  // calibration ranges of one side
  typedef struct packed {
    logic [SAMPLE_W-1:0] white_low;
    logic [SAMPLE_W-1:0] white_high;
    logic [SAMPLE_W-1:0] black_low;
    logic [SAMPLE_W-1:0] black_high;
  } cal_range_t;

  // capture command to the calibration store
  typedef struct packed {
    logic                en;
    logic [1:0]          mode;
    logic                side;
    logic [SAMPLE_W-1:0] sample;
  } cap_cmd_t;

  // operands for the shared divider
  typedef struct packed {
    logic [SAMPLE_W-1:0] rem_init;
    logic [7:0]          dividend_lo;
    logic [SAMPLE_W-1:0] divisor;
    logic [3:0]          steps;
  } div_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_PCT,
    S_WHT,
    S_WWAIT,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/lscc_cal_store.sv =====
// calibration store: half range register and per-side white/black ranges
// depends on lscc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lscc_cal_store (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [1:0]                 cfg_idx_i,
  input  wire  [lscc_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  wire                        rd_side_i,
  output lscc_pkg::cal_range_t       rd_range_o,
  input  wire  lscc_pkg::cap_cmd_t   cap_i
);

  logic [lscc_pkg::SAMPLE_W-1:0] half_q;
  logic [lscc_pkg::SAMPLE_W-1:0] wl_q [2];
  logic [lscc_pkg::SAMPLE_W-1:0] wh_q [2];
  logic [lscc_pkg::SAMPLE_W-1:0] bl_q [2];
  logic [lscc_pkg::SAMPLE_W-1:0] bh_q [2];

  logic [lscc_pkg::SAMPLE_W:0]   sum_hi;
  logic [lscc_pkg::SAMPLE_W-1:0] cap_lo;
  logic [lscc_pkg::SAMPLE_W-1:0] cap_hi;

  // configuration writes; default bounds only apply at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= lscc_pkg::CAL_HALF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lscc_pkg::REG_CAL_HALF:  half_q <= cfg_wdata_i;
        lscc_pkg::REG_WHITE_DEF: half_q <= half_q;
        lscc_pkg::REG_BLACK_DEF: half_q <= half_q;
        default:                 half_q <= half_q;
      endcase
    end
  end

  // captured bounds, saturated to the converter range
  always_comb begin
    sum_hi = {1'b0, cap_i.sample} + {1'b0, half_q};
    cap_lo = (cap_i.sample >= half_q) ? (cap_i.sample - half_q) : '0;
    cap_hi = (sum_hi > {1'b0, lscc_pkg::ADC_MAX}) ? lscc_pkg::ADC_MAX
                                                  : sum_hi[lscc_pkg::SAMPLE_W-1:0];
  end

  // range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        wl_q[i] <= '0;
        wh_q[i] <= lscc_pkg::WHITE_DEF_RST;
        bl_q[i] <= lscc_pkg::BLACK_DEF_RST;
        bh_q[i] <= lscc_pkg::ADC_MAX;
      end
    end else if (cap_i.en) begin
      if (cap_i.mode == lscc_pkg::MODE_CAP_WHITE) begin
        wl_q[cap_i.side] <= cap_lo;
        wh_q[cap_i.side] <= cap_hi;
      end else if (cap_i.mode == lscc_pkg::MODE_CAP_BLACK) begin
        bl_q[cap_i.side] <= cap_lo;
        bh_q[cap_i.side] <= cap_hi;
      end
    end
  end

  // read port for the side in work
  assign rd_range_o.white_low  = wl_q[rd_side_i];
  assign rd_range_o.white_high = wh_q[rd_side_i];
  assign rd_range_o.black_low  = bl_q[rd_side_i];
  assign rd_range_o.black_high = bh_q[rd_side_i];

endmodule

`default_nettype wire

// ===== rtl/lscc_div_unit.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on lscc_pkg; initial remainder must be below the divisor
`timescale 1ns / 1ps
`default_nettype none

module lscc_div_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire lscc_pkg::div_op_t op_i,
  output logic                busy_o,
  output logic [7:0]          quot_o
);

  logic [lscc_pkg::SAMPLE_W-1:0] rem_q, rem_d;
  logic [lscc_pkg::SAMPLE_W-1:0] div_q;
  logic [7:0]                    lo_q;
  logic [7:0]                    quo_q;
  logic [3:0]                    cnt_q;
  logic                          busy_q;

  logic [lscc_pkg::SAMPLE_W:0]   trial;
  logic [lscc_pkg::SAMPLE_W:0]   diff;
  logic                          fits;

  // compare and subtract step
  always_comb begin
    trial = {rem_q, lo_q[7]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
    rem_d = fits ? diff[lscc_pkg::SAMPLE_W-1:0] : trial[lscc_pkg::SAMPLE_W-1:0];
  end

  // step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= op_i.steps;
    end else if (busy_q) begin
      busy_q <= (cnt_q != 4'd1);
      cnt_q  <= cnt_q - 4'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= op_i.rem_init;
      lo_q  <= op_i.dividend_lo;
      div_q <= op_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[6:0], 1'b0};
      quo_q <= {quo_q[6:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/line_sensor_calibrated_classifier.sv =====
// line sensor calibrated classifier: sequencer, classifier and result register
// depends on lscc_pkg, lscc_cal_store and lscc_div_unit
//
//   channel | signals                              | direction
//   in      | in_valid_i, in_ready_o, in_req_i     | request in
//   out     | out_valid_o, out_ready_i, out_res_o  | result out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | register write
//
// one request at a time, accepted only in idle; the result follows the classify
// step, the percent division and, when needed, the white level division on the
// shared divider (7 steps for percent, up to 8 more for white level)
// reset clears the sequencer, result valid and ranges to their defaults
// the next request is taken while a result waits; a stalled result holds
// the sequencer in its final state, and capture updates land with the result
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_calibrated_classifier (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire lscc_pkg::in_req_t        in_req_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output lscc_pkg::out_res_t            out_res_o,
  input  wire                           cfg_we_i,
  input  wire  [1:0]                    cfg_idx_i,
  input  wire  [lscc_pkg::SAMPLE_W-1:0] cfg_wdata_i
);

  localparam logic [3:0] PCT_STEPS = 4'd7;
  localparam logic [3:0] WHT_STEPS = 4'd8;

  lscc_pkg::state_e   state_q, state_d;
  lscc_pkg::in_req_t  req_q;
  lscc_pkg::out_res_t out_q;
  logic               out_valid_q;

  logic               color_q;
  logic [6:0]         pct_q;
  logic [8:0]         wht_q;
  logic               wht_div_q;
  logic [lscc_pkg::SAMPLE_W-1:0] num_q;
  logic [lscc_pkg::SAMPLE_W-1:0] span_q;

  lscc_pkg::cal_range_t rng;
  lscc_pkg::cap_cmd_t   cap;
  lscc_pkg::div_op_t    div_op;
  logic                 div_start;
  logic                 div_busy;
  logic [7:0]           div_quot;
  logic                 out_free;

  // classifier terms
  logic [lscc_pkg::SAMPLE_W:0]   w_sum, b_sum, span_full, num_full;
  logic [lscc_pkg::SAMPLE_W-1:0] wc, bc, dw, db, span_eff;
  logic                          in_white, in_black, color_c, span_pos, num_pos;
  logic [18:0]                   pct_num;

  lscc_cal_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_side_i   (req_q.side),
    .rd_range_o  (rng),
    .cap_i       (cap)
  );

  lscc_div_unit u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .op_i    (div_op),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // color decision and white level setup from the held ranges
  always_comb begin
    in_white  = (req_q.sample >= rng.white_low) && (req_q.sample <= rng.white_high);
    in_black  = (req_q.sample >= rng.black_low) && (req_q.sample <= rng.black_high);
    w_sum     = {1'b0, rng.white_low} + {1'b0, rng.white_high};
    b_sum     = {1'b0, rng.black_low} + {1'b0, rng.black_high};
    wc        = w_sum[lscc_pkg::SAMPLE_W:1];
    bc        = b_sum[lscc_pkg::SAMPLE_W:1];
    dw        = (req_q.sample >= wc) ? (req_q.sample - wc) : (wc - req_q.sample);
    db        = (req_q.sample >= bc) ? (req_q.sample - bc) : (bc - req_q.sample);
    color_c   = in_white ? 1'b0 : (in_black ? 1'b1 : ((dw < db) ? 1'b0 : 1'b1));
    span_full = {1'b0, rng.black_low} - {1'b0, rng.white_high};
    num_full  = {1'b0, rng.black_low} - {1'b0, req_q.sample};
    span_pos  = !span_full[lscc_pkg::SAMPLE_W] && (span_full != '0);
    num_pos   = !num_full[lscc_pkg::SAMPLE_W] && (num_full != '0);
    span_eff  = span_pos ? span_full[lscc_pkg::SAMPLE_W-1:0] : 12'd1;
    // sample times 100 as shifts and adds
    pct_num   = {1'b0, req_q.sample, 6'b0} + {2'b0, req_q.sample, 5'b0}
              + {5'b0, req_q.sample, 2'b0};
  end

  // divider operand select
  always_comb begin
    if (state_q == lscc_pkg::S_CLASS) begin
      div_op.rem_init    = pct_num[18:7];
      div_op.dividend_lo = {pct_num[6:0], 1'b0};
      div_op.divisor     = lscc_pkg::ADC_MAX;
      div_op.steps       = PCT_STEPS;
    end else begin
      div_op.rem_init    = num_q;
      div_op.dividend_lo = 8'd0;
      div_op.divisor     = span_q;
      div_op.steps       = WHT_STEPS;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer next state and strobes
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    cap        = '{en: 1'b0, mode: req_q.mode, side: req_q.side, sample: req_q.sample};
    case (state_q)
      lscc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = lscc_pkg::S_CLASS;
      end
      lscc_pkg::S_CLASS: begin
        div_start = 1'b1;
        state_d   = lscc_pkg::S_PCT;
      end
      lscc_pkg::S_PCT: begin
        if (!div_busy) state_d = lscc_pkg::S_WHT;
      end
      lscc_pkg::S_WHT: begin
        if (wht_div_q) begin
          div_start = 1'b1;
          state_d   = lscc_pkg::S_WWAIT;
        end else begin
          state_d = lscc_pkg::S_DONE;
        end
      end
      lscc_pkg::S_WWAIT: begin
        if (!div_busy) state_d = lscc_pkg::S_DONE;
      end
      lscc_pkg::S_DONE: begin
        if (out_free) begin
          cap.en  = 1'b1;
          state_d = lscc_pkg::S_IDLE;
        end
      end
      default: state_d = lscc_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lscc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request and working registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (state_q == lscc_pkg::S_CLASS) begin
      color_q   <= color_c;
      num_q     <= num_full[lscc_pkg::SAMPLE_W-1:0];
      span_q    <= span_eff;
      wht_div_q <= 1'b0;
      if (!num_pos) begin
        wht_q <= 9'd0;
      end else if (num_full[lscc_pkg::SAMPLE_W-1:0] >= span_eff) begin
        wht_q <= 9'd256;
      end else begin
        wht_div_q <= 1'b1;
        wht_q     <= 9'd0;
      end
    end
    if ((state_q == lscc_pkg::S_PCT) && !div_busy) begin
      pct_q <= div_quot[6:0];
    end
    if ((state_q == lscc_pkg::S_WWAIT) && !div_busy) begin
      wht_q <= {1'b0, div_quot};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cap.en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap.en) begin
      out_q <= '{color: color_q, percent: pct_q, white_level: wht_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire
